@@ src/sasq_pkg.sv @@
// ----------------------------------------------------------------------------
// sasq_pkg
// shared types, codes and sizes of the shared array queue and stack unit
// ----------------------------------------------------------------------------
`default_nettype none

package sasq_pkg;

  // array depth and the widths that follow from it
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int RIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // common width for comparing counts with field values
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_Q_PUSH = 3'd0,
    MODE_S_PUSH = 3'd1,
    MODE_Q_POP  = 3'd2,
    MODE_S_POP  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_RANGE     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_op;
    logic exec;
  } sasq_cmd_t;

endpackage

`default_nettype wire

@@ src/sasq_in_if.sv @@
// ----------------------------------------------------------------------------
// sasq_in_if
// request channel: operation mode, push value and read index
// ----------------------------------------------------------------------------
`default_nettype none

interface sasq_in_if;
  import sasq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] push_value;
  logic [RIDX_W-1:0]        read_index;

  modport source (output valid, output mode, output push_value, output read_index,
                  input ready);
  modport sink   (input valid, input mode, input push_value, input read_index,
                  output ready);
endinterface

`default_nettype wire

@@ src/sasq_out_if.sv @@
// ----------------------------------------------------------------------------
// sasq_out_if
// response channel: status, data and both occupancy counts
// ----------------------------------------------------------------------------
`default_nettype none

interface sasq_out_if;
  import sasq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_W-1:0]       queue_count;
  logic [COUNT_W-1:0]       stack_count;

  modport source (output valid, output status, output data, output queue_count,
                  output stack_count, input ready);
  modport sink   (input valid, input status, input data, input queue_count,
                  input stack_count, output ready);
endinterface

`default_nettype wire

@@ src/shared_array_queue_and_stack_unit.sv @@
// ----------------------------------------------------------------------------
// shared_array_queue_and_stack_unit
// queue growing up and stack growing down inside one shared entry array
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        mode, push_value, read_index
//  out_o     out  valid/ready        status, data, queue_count, stack_count
//  cfg       in   cfg_we_i (no wait) cfg_wdata_i = capacity
//
//  each transaction first captures the request, then in the execute state
//  updates the entry array and loads the response register
//  the execute cycle waits while an earlier response is still not taken
//  a new request is taken while the last response waits in its register
//  reset empties both structures, zeroes all entries, capacity = DEPTH
//  a capacity write clears the array in the same cycle it is written
//
`default_nettype none

module shared_array_queue_and_stack_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sasq_pkg::CAP_W-1:0]  cfg_wdata_i,
  sasq_in_if.sink                          in_i,
  sasq_out_if.source                       out_o
);
  import sasq_pkg::*;

  sasq_cmd_t cmd;

  // handshake sequencing
  sasq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // storage, operation logic and response register
  sasq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (in_i.mode),
    .push_value_i  (in_i.push_value),
    .read_index_i  (in_i.read_index),
    .status_o      (out_o.status),
    .data_o        (out_o.data),
    .queue_count_o (out_o.queue_count),
    .stack_count_o (out_o.stack_count)
  );

endmodule

`default_nettype wire

@@ src/sasq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sasq_ctrl
// controller: takes a request, runs it once the response slot is free
// ----------------------------------------------------------------------------
`default_nettype none

module sasq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sasq_pkg::sasq_cmd_t     cmd_o
);
  import sasq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_op = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_op = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || out_ready_i))
    else $error("response overwritten before it was taken");

  a_exec_gives_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("executed request produced no response");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_op && cmd_o.exec))
    else $error("request loaded while another executes");

endmodule

`default_nettype wire

@@ src/sasq_dp.sv @@
// ----------------------------------------------------------------------------
// sasq_dp
// datapath: entry array, queue and stack lengths, capacity, response register
// ----------------------------------------------------------------------------
`default_nettype none

module sasq_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sasq_pkg::sasq_cmd_t            cmd_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [sasq_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  wire logic [sasq_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [sasq_pkg::DATA_W-1:0]    push_value_i,
  input  wire logic [sasq_pkg::RIDX_W-1:0]    read_index_i,
  output logic [sasq_pkg::STATUS_W-1:0]       status_o,
  output logic [sasq_pkg::DATA_W-1:0]         data_o,
  output logic [sasq_pkg::COUNT_W-1:0]        queue_count_o,
  output logic [sasq_pkg::COUNT_W-1:0]        stack_count_o
);
  import sasq_pkg::*;

  logic [DATA_W-1:0]   entries_q [DEPTH];
  logic [DATA_W-1:0]   entries_d [DEPTH];
  logic [DATA_W-1:0]   shifted   [DEPTH];
  logic [CNT_W-1:0]    qlen_q, qlen_d, slen_q, slen_d, cap_q, cap_d;
  logic [MODE_W-1:0]   mode_q;
  logic [DATA_W-1:0]   val_q;
  logic [RIDX_W-1:0]   ridx_q;
  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0]   data_q;
  logic [COUNT_W-1:0]  qc_q, sc_q;

  logic [CNT_W:0]      used;
  logic                full;
  logic [CNT_W-1:0]    top_pos, push_pos;
  logic [IDX_W-1:0]    rd_addr;
  logic [DATA_W-1:0]   rd_data;
  logic                ridx_out;
  logic [CAP_W-1:0]    cap_lim;
  status_e             stat;
  logic [DATA_W-1:0]   dat;

  assign used     = {1'b0, qlen_q} + {1'b0, slen_q};
  assign full     = used >= {1'b0, cap_q};
  assign top_pos  = cap_q - slen_q;
  assign push_pos = cap_q - slen_q - CNT_W'(1);
  assign ridx_out = CMP_W'(ridx_q) >= CMP_W'(cap_q);

  // single read port, address picked by the operation
  always_comb begin
    case (mode_q)
      MODE_S_POP: rd_addr = top_pos[IDX_W-1:0];
      MODE_READ:  rd_addr = IDX_W'(ridx_q);
      default:    rd_addr = '0;
    endcase
  end
  assign rd_data = entries_q[rd_addr];

  // queue contents moved down one slot
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) shifted[i] = entries_q[i + 1];
    shifted[DEPTH-1] = '0;
  end

  // capacity limited to 1..DEPTH
  always_comb begin
    cap_lim = cfg_wdata_i;
    if (cap_lim == '0) cap_lim = CAP_W'(1);
    if (CMP_W'(cap_lim) > CMP_W'(DEPTH)) cap_lim = CAP_W'(DEPTH);
  end

  always_comb begin
    entries_d = entries_q;
    qlen_d    = qlen_q;
    slen_d    = slen_q;
    cap_d     = cap_q;
    stat      = STAT_OK;
    dat       = '0;
    if (cmd_i.exec) begin
      case (mode_q)
        MODE_Q_PUSH: begin
          if (full) stat = STAT_OVERFLOW;
          else begin
            entries_d[qlen_q[IDX_W-1:0]] = val_q;
            qlen_d = qlen_q + CNT_W'(1);
          end
        end
        MODE_S_PUSH: begin
          if (full) stat = STAT_OVERFLOW;
          else begin
            entries_d[push_pos[IDX_W-1:0]] = val_q;
            slen_d = slen_q + CNT_W'(1);
          end
        end
        MODE_Q_POP: begin
          if (qlen_q == '0) stat = STAT_UNDERFLOW;
          else begin
            dat = rd_data;
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) < qlen_q - CNT_W'(1)) entries_d[i] = shifted[i];
              else if (CNT_W'(i) == qlen_q - CNT_W'(1)) entries_d[i] = '0;
            end
            qlen_d = qlen_q - CNT_W'(1);
          end
        end
        MODE_S_POP: begin
          if (slen_q == '0) stat = STAT_UNDERFLOW;
          else begin
            dat = rd_data;
            entries_d[top_pos[IDX_W-1:0]] = '0;
            slen_d = slen_q - CNT_W'(1);
          end
        end
        MODE_READ: begin
          if (ridx_out) stat = STAT_RANGE;
          else dat = rd_data;
        end
        default: ;
      endcase
    end
    // capacity write empties both structures
    if (cfg_we_i) begin
      for (int i = 0; i < DEPTH; i++) entries_d[i] = '0;
      qlen_d = '0;
      slen_d = '0;
      cap_d  = CNT_W'(cap_lim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) entries_q[i] <= '0;
      qlen_q <= '0;
      slen_q <= '0;
      cap_q  <= CNT_W'(DEPTH);
    end else begin
      entries_q <= entries_d;
      qlen_q    <= qlen_d;
      slen_q    <= slen_d;
      cap_q     <= cap_d;
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      mode_q <= mode_i;
      val_q  <= push_value_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.exec) begin
      status_q <= stat;
      data_q   <= dat;
      qc_q     <= COUNT_W'(qlen_d);
      sc_q     <= COUNT_W'(slen_d);
    end
  end

  assign status_o      = status_q;
  assign data_o        = data_q;
  assign queue_count_o = qc_q;
  assign stack_count_o = sc_q;

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (CMP_W'(cap_q) <= CMP_W'(DEPTH)))
    else $error("capacity outside 1..DEPTH");

  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= {1'b0, cap_q})
    else $error("queue and stack overlap");

endmodule

`default_nettype wire

@@ tb/sasq_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// sasq_scoreboard_pkg
// predicted state of the shared array and the queue of awaited responses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sasq_scoreboard_pkg;
  import sasq_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [DATA_W-1:0]    data;
    logic [COUNT_W-1:0]   queue_count;
    logic [COUNT_W-1:0]   stack_count;
  } reply_t;

  class sasq_scoreboard;
    logic [DATA_W-1:0] cells [DEPTH];
    int unsigned       queue_len;
    int unsigned       stack_len;
    int unsigned       capacity;
    reply_t            awaited_replies [$];
    int                errors;

    function new();
      capacity = DEPTH;
      errors   = 0;
      clear_array();
    endfunction

    function void clear_array();
      foreach (cells[i]) cells[i] = '0;
      queue_len = 0;
      stack_len = 0;
    endfunction

    // zero acts as one, anything past the array depth acts as the depth
    function void write_capacity(logic [CAP_W-1:0] value);
      capacity = 32'(value);
      if (capacity == 0) capacity = 1;
      if (capacity > DEPTH) capacity = DEPTH;
      clear_array();
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                               logic [RIDX_W-1:0] ridx);
      reply_t      reply;
      int unsigned top;
      reply = '{status: STAT_OK, data: '0, queue_count: '0, stack_count: '0};
      case (mode)
        MODE_Q_PUSH, MODE_S_PUSH: begin
          if (queue_len + stack_len >= capacity) begin
            reply.status = STAT_OVERFLOW;
          end else if (mode == MODE_Q_PUSH) begin
            cells[queue_len] = value;
            queue_len++;
          end else begin
            stack_len++;
            cells[capacity - stack_len] = value;
          end
        end
        MODE_Q_POP: begin
          if (queue_len == 0) begin
            reply.status = STAT_UNDERFLOW;
          end else begin
            reply.data = cells[0];
            for (int i = 1; i < queue_len; i++) cells[i-1] = cells[i];
            cells[queue_len-1] = '0;
            queue_len--;
          end
        end
        MODE_S_POP: begin
          if (stack_len == 0) begin
            reply.status = STAT_UNDERFLOW;
          end else begin
            top        = capacity - stack_len;
            reply.data = cells[top];
            cells[top] = '0;
            stack_len--;
          end
        end
        MODE_READ: begin
          if (ridx >= capacity) reply.status = STAT_RANGE;
          else reply.data = cells[ridx];
        end
        default: ;
      endcase
      reply.queue_count = COUNT_W'(queue_len);
      reply.stack_count = COUNT_W'(stack_len);
      awaited_replies.push_back(reply);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data,
                                 logic [COUNT_W-1:0] queue_count,
                                 logic [COUNT_W-1:0] stack_count);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("response with no request outstanding: status %0d data %h", status, data);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (data !== want.data) begin
        $error("data: expected %h, actual %h", want.data, data);
        errors++;
      end
      if (queue_count !== want.queue_count) begin
        $error("queue_count: expected %0d, actual %0d", want.queue_count, queue_count);
        errors++;
      end
      if (stack_count !== want.stack_count) begin
        $error("stack_count: expected %0d, actual %0d", want.stack_count, stack_count);
        errors++;
      end
    endfunction
  endclass

endpackage

`default_nettype wire

@@ tb/shared_array_queue_and_stack_unit_test.sv @@
// ----------------------------------------------------------------------------
// shared_array_queue_and_stack_unit_test
// drives pushes, pops, reads and spare modes through the request channel
// under a range of capacities, with random gaps on both sides, and checks
// every response against a predicted copy of the shared array
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shared_array_queue_and_stack_unit_test;
  import sasq_pkg::*;
  import sasq_scoreboard_pkg::*;

  localparam int MAX_GAP          = 19;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 83;
  localparam int CYCLE_LIMIT      = 400000;
  // mode codes past the last defined operation
  localparam int SPARE_MODE_FIRST = int'(MODE_READ) + 1;
  localparam int SPARE_MODE_LAST  = (1 << MODE_W) - 1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CAP_W-1:0]    cfg_wdata_i;

  sasq_in_if  in_ch ();
  sasq_out_if out_ch ();

  shared_array_queue_and_stack_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  sasq_scoreboard board = new();

  // pacing controls, written by the stimulus process only, and the watchdog's cycle counter
  bit          send_quiet;
  bit          recv_quiet;
  int          hold_asks;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shared_array_queue_and_stack_unit_test failed");
      $finish;
    end
  end

  // one request transaction: optional gap with valid low, then hold valid
  // until the block takes it; the prediction is made at acceptance
  task automatic offer(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                       input logic [RIDX_W-1:0] ridx);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.push_value <= value;
    in_ch.read_index <= ridx;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    board.note_request(mode, value, ridx);
    @(negedge clk_i);
  endtask

  // sender pause: every awaited response has to come back first
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // capacity writes only happen with the block idle
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.write_capacity(value);
  endtask

  // response side: random stall before each transaction, plus one long
  // hold-off on request so the block backs up into the request channel
  initial begin
    int stall;
    int hold_done;
    out_ch.ready = 1'b0;
    hold_done    = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        stall     = HOLD_CYCLES;
      end else begin
        stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      board.check_response(out_ch.status, out_ch.data, out_ch.queue_count,
                           out_ch.stack_count);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CAP_W-1:0]  cap;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    bit                filling;
    int                burst;
    int                roll;

    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_Q_PUSH;
    in_ch.push_value = '0;
    in_ch.read_index = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    send_quiet       = 1'b0;
    recv_quiet       = 1'b0;
    hold_asks        = 0;
    rst_ni           = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, at the reset capacity of the full depth
    offer(MODE_Q_POP, '0, '0);                   // queue underflow
    offer(MODE_S_POP, '0, '0);                   // stack underflow
    offer(MODE_Q_PUSH, 32'h7fff_ffff, '0);
    offer(MODE_Q_PUSH, 32'h8000_0000, '0);
    offer(MODE_Q_PUSH, 32'h0000_0000, '0);       // zero is stored like any value
    offer(MODE_S_PUSH, 32'hffff_ffff, '0);
    offer(MODE_S_PUSH, 32'h0000_0000, '0);
    offer(MODE_READ, '0, 4'd0);
    offer(MODE_READ, '0, 4'd15);                 // stack bottom at the last entry
    offer(MODE_READ, '0, 4'd7);                  // untouched middle entry
    offer(MODE_Q_POP, '0, '0);                   // head comes out, rest shifts down
    offer(MODE_READ, '0, 4'd2);                  // freed slot reads back zero
    offer(MODE_S_POP, '0, '0);
    offer(MODE_W'(SPARE_MODE_FIRST), 32'hffff_ffff, 4'd15);
    offer(MODE_W'(SPARE_MODE_FIRST + 1), '0, '0);
    offer(MODE_W'(SPARE_MODE_LAST), 32'h5a5a_a5a5, 4'd9);

    // a write of zero acts as a capacity of one and empties everything
    set_capacity('0);
    offer(MODE_READ, '0, 4'd0);
    offer(MODE_READ, '0, 4'd1);                  // index beyond capacity
    offer(MODE_Q_PUSH, 32'h1234_5678, '0);
    offer(MODE_Q_PUSH, 32'h0bad_f00d, '0);       // overflow, the two have met
    offer(MODE_S_PUSH, 32'h0bad_f00d, '0);
    offer(MODE_Q_POP, '0, '0);
    offer(MODE_S_PUSH, 32'h8000_0000, '0);
    offer(MODE_S_POP, '0, '0);
    offer(MODE_S_POP, '0, '0);

    // random phases: alternating fill and drain bursts so both structures
    // run into overflow and underflow at every capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = 5'd31;                      // clipped to the depth
        1:       cap = 5'd2;
        2:       cap = 5'd16;
        3:       cap = 5'd1;
        4:       cap = 5'd17;
        5:       cap = 5'd7;
        6:       cap = 5'd16;
        default: cap = CAP_W'($urandom_range(0, (1 << CAP_W) - 1));
      endcase
      set_capacity(cap);
      // phase 2 runs with no idling at all, phase 4 stalls the response
      // side for a long stretch while requests keep coming back to back
      send_quiet = (ph == 2) || (ph == 4);
      recv_quiet = (ph == 2);
      if (ph == 4) hold_asks = hold_asks + 1;
      filling = 1'b0;
      burst   = 0;
      repeat (PHASE_ITEMS) begin
        if (burst == 0) begin
          filling = !filling;
          burst   = $urandom_range(3, 20);
        end
        burst = burst - 1;
        roll  = $urandom_range(0, 99);
        if (roll < 4)
          mode = MODE_W'($urandom_range(SPARE_MODE_FIRST, SPARE_MODE_LAST));
        else if (roll < 16)
          mode = MODE_READ;
        else if (filling == (roll < 74))
          mode = $urandom_range(0, 1) ? MODE_Q_PUSH : MODE_S_PUSH;
        else
          mode = $urandom_range(0, 1) ? MODE_Q_POP : MODE_S_POP;
        case ($urandom_range(0, 7))
          0:       value = 32'h0000_0000;
          1:       value = 32'h7fff_ffff;
          2:       value = 32'h8000_0000;
          3:       value = 32'hffff_ffff;
          default: value = $urandom();
        endcase
        offer(mode, value, RIDX_W'($urandom_range(0, (1 << RIDX_W) - 1)));
      end
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("shared_array_queue_and_stack_unit_test passed");
    end else begin
      $display("shared_array_queue_and_stack_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
